// ===== hdl/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types and codes for the array linked list engine: operation and
// status codes, default sizes, and the request and result beat layouts.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [3:0] OP_INS_AFTER = 4'd0;
  localparam logic [3:0] OP_PUSH_HEAD = 4'd1;
  localparam logic [3:0] OP_PUSH_TAIL = 4'd2;
  localparam logic [3:0] OP_DELETE    = 4'd3;
  localparam logic [3:0] OP_DEL_HEAD  = 4'd4;
  localparam logic [3:0] OP_DEL_TAIL  = 4'd5;
  localparam logic [3:0] OP_WRITE     = 4'd6;
  localparam logic [3:0] OP_READ      = 4'd7;
  localparam logic [3:0] OP_NEXT      = 4'd8;
  localparam logic [3:0] OP_PREV      = 4'd9;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_ANCHOR = 2'd1;
  localparam logic [1:0] STAT_FULL       = 2'd2;
  localparam logic [1:0] STAT_EMPTY      = 2'd3;

  typedef struct packed {
    logic [3:0]  operation;
    logic [7:0]  anchor;
    logic [31:0] data_in;
  } alle_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [7:0]  node_out;
    logic [7:0]  head_node;
    logic [7:0]  tail_node;
    logic [7:0]  element_count;
  } alle_out_t;

endpackage

// ===== hdl/array_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Circular doubly linked list with sentinel node 0 and a free chain, kept in
// a link memory {used, prev, next} and a data memory.
//
//   channel   ports                 handshake
//   request   in_req                start high while busy low
//   result    out_res               out_valid strobe, one cycle, no stall
//
// After reset a clearing pass writes every link entry, with busy high. Read,
// write, next, prev, failed and unknown requests finish in the check state;
// insert, push and delete go on through RD2, RD3, WR2 and WR3, set by the
// link memory's single write port (three read and three write accesses).
// The result strobe comes in the cycle after the last memory access;
// a new request may be accepted in that same cycle.
// ----------------------------------------------------------------------------
module array_linked_list_engine
  import alle_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  alle_in_t  in_req,
  output logic      out_valid,
  output alle_out_t out_res
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int LW = 2 * IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NODE_COUNT - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_RD2  = 3'd3;
  localparam logic [2:0] ST_RD3  = 3'd4;
  localparam logic [2:0] ST_WR2  = 3'd5;
  localparam logic [2:0] ST_WR3  = 3'd6;

  typedef struct packed {
    logic          used;
    logic [IW-1:0] bwd;
    logic [IW-1:0] fwd;
  } link_t;

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  alle_in_t      req_r, req_nxt;
  logic [IW-1:0] a_r, a_nxt;
  logic          far_r, far_nxt;
  logic          ins_r, ins_nxt;
  link_t         wa_r, wa_nxt;
  link_t         w2_r, w2_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   dout_r, dout_nxt;
  logic [IW-1:0] node_r, node_nxt;

  // memory ports
  logic                  link_we;
  logic [IW-1:0]         link_waddr, link_raddr;
  link_t                 link_wdata, link_rd;
  logic [LW-1:0]         link_rdata;
  logic                  data_we;
  logic [IW-1:0]         data_waddr, data_raddr;
  logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

  // decode of the incoming beat
  logic [IW-1:0] a_sel;
  logic          a_far;
  logic          live, elem, finish;

  // words written by insert and delete
  logic  ins_alias, del_alias;
  link_t word_a, word_n, word_af, word_p, word_x, word_free;

  alle_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  alle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODE_COUNT)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  assign link_rd = link_rdata;

  always_comb begin
    case (in_req.operation)
      OP_PUSH_HEAD: a_sel = '0;
      OP_PUSH_TAIL: a_sel = tail_r;
      OP_DEL_TAIL:  a_sel = tail_r;
      OP_DEL_HEAD:  a_sel = head_r;
      default:      a_sel = IW'(in_req.anchor);
    endcase
    a_far = (32'(in_req.anchor) >= NODE_COUNT) &&
            !(in_req.operation inside {OP_PUSH_HEAD, OP_PUSH_TAIL, OP_DEL_HEAD, OP_DEL_TAIL});
  end

  // insert: wa_r is the anchor, w2_r the new node, third read the old successor
  // delete: wa_r is the victim, w2_r its predecessor, third read its successor
  always_comb begin
    ins_alias = (wa_r.fwd == a_r);
    word_a    = '{used: wa_r.used, bwd: ins_alias ? free_head_r : wa_r.bwd, fwd: free_head_r};
    word_n    = '{used: 1'b1, bwd: a_r, fwd: wa_r.fwd};
    word_af   = ins_alias ? word_a :
                link_t'{used: link_rd.used, bwd: free_head_r, fwd: link_rd.fwd};

    del_alias = (wa_r.bwd == wa_r.fwd);
    word_p    = '{used: w2_r.used, bwd: del_alias ? wa_r.bwd : w2_r.bwd, fwd: wa_r.fwd};
    word_x    = del_alias ? word_p :
                link_t'{used: link_rd.used, bwd: wa_r.bwd, fwd: link_rd.fwd};
    word_free = '{used: 1'b0, bwd: '0, fwd: free_head_r};
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    req_nxt       = req_r;
    a_nxt         = a_r;
    far_nxt       = far_r;
    ins_nxt       = ins_r;
    wa_nxt        = wa_r;
    w2_nxt        = w2_r;
    status_nxt    = status_r;
    dout_nxt      = dout_r;
    node_nxt      = node_r;

    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_raddr = '0;
    data_we    = 1'b0;
    data_waddr = a_r;
    data_wdata = DATA_WIDTH'(req_r.data_in);
    data_raddr = '0;

    live   = !far_r && link_rd.used;
    elem   = live && (a_r != '0);
    finish = 1'b0;

    case (state_r)
      ST_CLR: begin
        link_we    = 1'b1;
        link_waddr = clr_r;
        link_wdata = '{used: (clr_r == '0), bwd: '0,
                       fwd: (clr_r == '0) ? '0 : clr_r - 1'b1};
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        link_raddr = a_sel;
        data_raddr = a_sel;
        if (start) begin
          req_nxt   = in_req;
          a_nxt     = a_sel;
          far_nxt   = a_far;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        wa_nxt     = link_rd;
        status_nxt = STAT_OK;
        dout_nxt   = '0;
        node_nxt   = '0;
        case (req_r.operation)
          OP_INS_AFTER, OP_PUSH_HEAD, OP_PUSH_TAIL: begin
            if (!live) begin
              status_nxt = STAT_BAD_ANCHOR;
              finish     = 1'b1;
            end else if (free_head_r == '0) begin
              status_nxt = STAT_FULL;
              finish     = 1'b1;
            end else begin
              link_raddr = free_head_r;
              ins_nxt    = 1'b1;
              state_nxt  = ST_RD2;
            end
          end
          OP_DELETE, OP_DEL_HEAD, OP_DEL_TAIL: begin
            if (req_r.operation != OP_DELETE && count_r == '0) begin
              status_nxt = STAT_EMPTY;
              finish     = 1'b1;
            end else if (!elem) begin
              status_nxt = STAT_BAD_ANCHOR;
              finish     = 1'b1;
            end else begin
              link_raddr = link_rd.bwd;
              ins_nxt    = 1'b0;
              state_nxt  = ST_RD2;
            end
          end
          OP_WRITE: begin
            finish = 1'b1;
            if (!elem) begin
              status_nxt = STAT_BAD_ANCHOR;
            end else begin
              data_we = 1'b1;
            end
          end
          OP_READ: begin
            finish = 1'b1;
            if (!elem) begin
              status_nxt = STAT_BAD_ANCHOR;
            end else begin
              dout_nxt = 32'(data_rdata);
            end
          end
          OP_NEXT, OP_PREV: begin
            finish = 1'b1;
            if (!live) begin
              status_nxt = STAT_BAD_ANCHOR;
            end else begin
              node_nxt = (req_r.operation == OP_NEXT) ? link_rd.fwd : link_rd.bwd;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD2: begin
        w2_nxt     = link_rd;
        link_raddr = wa_r.fwd;
        state_nxt  = ST_RD3;
      end
      ST_RD3: begin
        link_we    = 1'b1;
        link_waddr = wa_r.fwd;
        link_wdata = ins_r ? word_af : word_x;
        state_nxt  = ST_WR2;
      end
      ST_WR2: begin
        link_we    = 1'b1;
        link_waddr = ins_r ? a_r : wa_r.bwd;
        link_wdata = ins_r ? word_a : word_p;
        state_nxt  = ST_WR3;
      end
      ST_WR3: begin
        link_we   = 1'b1;
        finish    = 1'b1;
        state_nxt = ST_IDLE;
        if (ins_r) begin
          link_waddr    = free_head_r;
          link_wdata    = word_n;
          data_we       = 1'b1;
          data_waddr    = free_head_r;
          free_head_nxt = w2_r.fwd;
          count_nxt     = count_r + 1'b1;
          node_nxt      = free_head_r;
        end else begin
          link_waddr    = a_r;
          link_wdata    = word_free;
          free_head_nxt = a_r;
          count_nxt     = count_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // sentinel entry mirrored for head and tail
    if (link_we && link_waddr == '0) begin
      head_nxt = link_wdata.fwd;
      tail_nxt = link_wdata.bwd;
    end

    out_valid_nxt = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      free_head_r <= LAST_IDX;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    a_r      <= a_nxt;
    far_r    <= far_nxt;
    ins_r    <= ins_nxt;
    wa_r     <= wa_nxt;
    w2_r     <= w2_nxt;
    status_r <= status_nxt;
    dout_r   <= dout_nxt;
    node_r   <= node_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_res.status        = status_r;
    out_res.data_out      = dout_r;
    out_res.node_out      = 8'(node_r);
    out_res.head_node     = 8'(head_r);
    out_res.tail_node     = 8'(tail_r);
    out_res.element_count = 8'(count_r);
  end

endmodule

// ===== hdl/alle_ram.sv =====
// ----------------------------------------------------------------------------
// alle_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data. A read of the address written in the same cycle returns old data.
// ----------------------------------------------------------------------------
module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
